// ===== rtl/qcs_pkg.sv =====
// ============================================================================
// qcs_pkg - shared types and constants for the quad corner sort core
// Corner status codes, corner index type and pipeline enable bundle.
// ============================================================================
package qcs_pkg;

   localparam int NUM_PTS = 3;
   localparam int NUM_CRN = 4;

   // corner status codes
   localparam logic [1:0] STAT_FOUND  = 2'd1;
   localparam logic [1:0] STAT_INTERP = 2'd2;

   typedef logic [1:0] crn_idx_type;

   // per-stage load enables, driven by the top level's ready chain
   typedef struct packed {
      logic en_sq;
      logic en_sum;
      logic en_asg;
      logic en_out;
   } pipe_ctl_type;

endpackage

// ===== rtl/qcs_lane.sv =====
// ============================================================================
// qcs_lane - distance lane for one point
// Squares the x/y offsets to the box edges, then sums them into the four
// squared corner distances. Carries its point along both stages.
// ============================================================================
module qcs_lane #(
   parameter int W = 16
) (
   input  logic                       clock,
   input  qcs_pkg::pipe_ctl_type      ctl,
   input  logic signed [W-1:0]        pt_x,
   input  logic signed [W-1:0]        pt_y,
   input  logic signed [W-1:0]        min_x,
   input  logic signed [W-1:0]        max_x,
   input  logic signed [W-1:0]        min_y,
   input  logic signed [W-1:0]        max_y,
   output logic signed [W-1:0]        pt_x_o,
   output logic signed [W-1:0]        pt_y_o,
   output logic [2*W:0]               crn_dist [qcs_pkg::NUM_CRN]
);

   function automatic logic [W-1:0] mag_diff(input logic signed [W-1:0] a,
                                             input logic signed [W-1:0] b);
      logic signed [W:0] d;
      d = (W+1)'(a) - (W+1)'(b);
      return d[W] ? W'(-d) : W'(d);
   endfunction

   logic [W-1:0]          mx_lo, mx_hi, my_lo, my_hi;
   logic [2*W-1:0]        sqx_lo_ff, sqx_hi_ff, sqy_lo_ff, sqy_hi_ff;
   logic [2*W-1:0]        sqx_lo_in, sqx_hi_in, sqy_lo_in, sqy_hi_in;
   logic signed [W-1:0]   ptx_sq_ff, pty_sq_ff;
   logic signed [W-1:0]   ptx_sum_ff, pty_sum_ff;
   logic [2*W:0]          dist_ff [qcs_pkg::NUM_CRN];
   logic [2*W:0]          dist_in [qcs_pkg::NUM_CRN];

   always_comb begin
      mx_lo     = mag_diff(pt_x, min_x);
      mx_hi     = mag_diff(pt_x, max_x);
      my_lo     = mag_diff(pt_y, min_y);
      my_hi     = mag_diff(pt_y, max_y);
      sqx_lo_in = mx_lo * mx_lo;
      sqx_hi_in = mx_hi * mx_hi;
      sqy_lo_in = my_lo * my_lo;
      sqy_hi_in = my_hi * my_hi;
   end

   // corner order: (min,min) (max,min) (min,max) (max,max)
   always_comb begin
      dist_in[0] = {1'b0, sqx_lo_ff} + {1'b0, sqy_lo_ff};
      dist_in[1] = {1'b0, sqx_hi_ff} + {1'b0, sqy_lo_ff};
      dist_in[2] = {1'b0, sqx_lo_ff} + {1'b0, sqy_hi_ff};
      dist_in[3] = {1'b0, sqx_hi_ff} + {1'b0, sqy_hi_ff};
   end

   always_ff @(posedge clock) begin
      if (ctl.en_sq) begin
         sqx_lo_ff <= sqx_lo_in;
         sqx_hi_ff <= sqx_hi_in;
         sqy_lo_ff <= sqy_lo_in;
         sqy_hi_ff <= sqy_hi_in;
         ptx_sq_ff <= pt_x;
         pty_sq_ff <= pt_y;
      end
      if (ctl.en_sum) begin
         dist_ff    <= dist_in;
         ptx_sum_ff <= ptx_sq_ff;
         pty_sum_ff <= pty_sq_ff;
      end
   end

   assign pt_x_o   = ptx_sum_ff;
   assign pt_y_o   = pty_sum_ff;
   assign crn_dist = dist_ff;

endmodule

// ===== rtl/qcs_merge.sv =====
// ============================================================================
// qcs_merge - corner assignment and completion
// Greedy nearest-free-corner assignment over the lane distances, then
// extrapolation of the one leftover corner with halving and saturation.
// ============================================================================
module qcs_merge #(
   parameter int W = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  qcs_pkg::pipe_ctl_type ctl,
   input  logic                  asg_vld,
   input  logic                  any_in,
   input  logic [2*W:0]          crn_dist [qcs_pkg::NUM_PTS][qcs_pkg::NUM_CRN],
   input  logic signed [W-1:0]   pt_x [qcs_pkg::NUM_PTS],
   input  logic signed [W-1:0]   pt_y [qcs_pkg::NUM_PTS],
   output logic signed [W-1:0]   crn_x [qcs_pkg::NUM_CRN],
   output logic signed [W-1:0]   crn_y [qcs_pkg::NUM_CRN],
   output logic [1:0]            stat [qcs_pkg::NUM_CRN]
);

   localparam logic signed [W-1:0] HI_W = {1'b0, {(W-1){1'b1}}};
   localparam logic signed [W-1:0] LO_W = {1'b1, {(W-1){1'b0}}};

   logic [qcs_pkg::NUM_CRN-1:0] tk_in, taken_ff;
   qcs_pkg::crn_idx_type        sel_in [qcs_pkg::NUM_PTS];
   qcs_pkg::crn_idx_type        sel_ff [qcs_pkg::NUM_PTS];
   logic signed [W-1:0]         ptx_ff [qcs_pkg::NUM_PTS];
   logic signed [W-1:0]         pty_ff [qcs_pkg::NUM_PTS];
   logic                        any_asg_ff;

   logic signed [W-1:0]         cx [qcs_pkg::NUM_CRN];
   logic signed [W-1:0]         cy [qcs_pkg::NUM_CRN];
   qcs_pkg::crn_idx_type        fk;
   logic signed [W+2:0]         sx, sy, hx, hy;
   logic signed [W-1:0]         ex, ey;

   logic signed [W-1:0]         crn_x_ff [qcs_pkg::NUM_CRN];
   logic signed [W-1:0]         crn_y_ff [qcs_pkg::NUM_CRN];
   logic [1:0]                  stat_ff  [qcs_pkg::NUM_CRN];
   logic signed [W-1:0]         crn_x_in [qcs_pkg::NUM_CRN];
   logic signed [W-1:0]         crn_y_in [qcs_pkg::NUM_CRN];
   logic [1:0]                  stat_in  [qcs_pkg::NUM_CRN];

   // points in order, each to the nearest free corner; strict < keeps the
   // lower index on ties. Without a box, first free corner wins.
   always_comb begin
      qcs_pkg::crn_idx_type best;
      logic                 hit;
      logic [2*W:0]         bd;
      tk_in = '0;
      for (int n = 0; n < qcs_pkg::NUM_PTS; n++) begin
         best = '0;
         hit  = 1'b0;
         bd   = '0;
         for (int m = 0; m < qcs_pkg::NUM_CRN; m++) begin
            if (!tk_in[m] && (!hit || (any_in && (crn_dist[n][m] < bd)))) begin
               best = 2'(m);
               bd   = crn_dist[n][m];
               hit  = 1'b1;
            end
         end
         tk_in[best] = 1'b1;
         sel_in[n]   = best;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.en_asg) begin
         taken_ff   <= tk_in;
         sel_ff     <= sel_in;
         ptx_ff     <= pt_x;
         pty_ff     <= pt_y;
         any_asg_ff <= any_in;
      end
   end

   // placed corners; the free one reads as zero
   always_comb begin
      fk = '0;
      for (int k = 0; k < qcs_pkg::NUM_CRN; k++) begin
         cx[k] = '0;
         cy[k] = '0;
         for (int n = 0; n < qcs_pkg::NUM_PTS; n++) begin
            if (sel_ff[n] == 2'(k)) begin
               cx[k] = ptx_ff[n];
               cy[k] = pty_ff[n];
            end
         end
         if (!taken_ff[k]) begin
            fk = 2'(k);
         end
      end
   end

   // extrapolation from the two neighbours and the opposite corner, halved toward minus infinity, saturated
   always_comb begin
      sx = ((W+3)'(cx[fk ^ 2'd2]) <<< 1) + (W+3)'(cx[fk ^ 2'd1]) - (W+3)'(cx[fk ^ 2'd3]);
      sy = ((W+3)'(cy[fk ^ 2'd1]) <<< 1) + (W+3)'(cy[fk ^ 2'd2]) - (W+3)'(cy[fk ^ 2'd3]);
      hx = sx >>> 1;
      hy = sy >>> 1;
      if (hx > (W+3)'(HI_W)) begin
         ex = HI_W;
      end else if (hx < (W+3)'(LO_W)) begin
         ex = LO_W;
      end else begin
         ex = W'(hx);
      end
      if (hy > (W+3)'(HI_W)) begin
         ey = HI_W;
      end else if (hy < (W+3)'(LO_W)) begin
         ey = LO_W;
      end else begin
         ey = W'(hy);
      end
      for (int k = 0; k < qcs_pkg::NUM_CRN; k++) begin
         crn_x_in[k] = taken_ff[k] ? cx[k] : ex;
         crn_y_in[k] = taken_ff[k] ? cy[k] : ey;
         stat_in[k]  = taken_ff[k] ? qcs_pkg::STAT_FOUND : qcs_pkg::STAT_INTERP;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.en_out) begin
         crn_x_ff <= crn_x_in;
         crn_y_ff <= crn_y_in;
         stat_ff  <= stat_in;
      end
   end

   assign crn_x = crn_x_ff;
   assign crn_y = crn_y_ff;
   assign stat  = stat_ff;

   a_three_taken: assert property (@(posedge clock) disable iff (reset)
      asg_vld |-> ($countones(taken_ff) == 3))
      else $error("assignment does not occupy exactly three corners");

   a_no_box_order: assert property (@(posedge clock) disable iff (reset)
      (asg_vld && !any_asg_ff) |-> (sel_ff[0] == 2'd0 && sel_ff[1] == 2'd1 &&
                                    sel_ff[2] == 2'd2))
      else $error("without found points, points must fill corners in order");

endmodule

// ===== rtl/quad_corner_sort_and_complete_core.sv =====
// ============================================================================
// quad_corner_sort_and_complete_core - sort three points into quad corners
// Bounding box of found points, per-point distance lanes, greedy corner
// assignment and extrapolation of the leftover corner.
// ============================================================================
//
//   channel  handshake              payload
//   req      req_valid/req_ready    req_p{0..2}_{x,y}, req_found{0..2}
//   rsp      rsp_valid/rsp_ready    rsp_c{0..3}_{x,y}, rsp_stat{0..3}
//
// One transaction per cycle sustained while rsp_ready stays high; the registered stages
// from request acceptance to response valid are box, square, sum, assign and complete.
// Each stage holds while the one after it is full and stalled, so a full
// pipeline absorbs rsp_ready low without losing a transaction.
// Synchronous reset empties the pipeline; no state carries between items.
//
module quad_corner_sort_and_complete_core #(
   parameter int COORD_BITS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic signed [COORD_BITS-1:0] req_p0_x,
   input  logic signed [COORD_BITS-1:0] req_p0_y,
   input  logic signed [COORD_BITS-1:0] req_p1_x,
   input  logic signed [COORD_BITS-1:0] req_p1_y,
   input  logic signed [COORD_BITS-1:0] req_p2_x,
   input  logic signed [COORD_BITS-1:0] req_p2_y,
   input  logic                         req_found0,
   input  logic                         req_found1,
   input  logic                         req_found2,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic signed [COORD_BITS-1:0] rsp_c0_x,
   output logic signed [COORD_BITS-1:0] rsp_c0_y,
   output logic signed [COORD_BITS-1:0] rsp_c1_x,
   output logic signed [COORD_BITS-1:0] rsp_c1_y,
   output logic signed [COORD_BITS-1:0] rsp_c2_x,
   output logic signed [COORD_BITS-1:0] rsp_c2_y,
   output logic signed [COORD_BITS-1:0] rsp_c3_x,
   output logic signed [COORD_BITS-1:0] rsp_c3_y,
   output logic [1:0]                   rsp_stat0,
   output logic [1:0]                   rsp_stat1,
   output logic [1:0]                   rsp_stat2,
   output logic [1:0]                   rsp_stat3
);

   localparam int W = COORD_BITS;

   // pipeline control
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic v1_in, v2_in, v3_in, v4_in, v5_in;
   logic rdy2, rdy3, rdy4, rdy5;
   qcs_pkg::pipe_ctl_type ctl;

   assign rdy5      = !v5_ff || rsp_ready;
   assign rdy4      = !v4_ff || rdy5;
   assign rdy3      = !v3_ff || rdy4;
   assign rdy2      = !v2_ff || rdy3;
   assign req_ready = !v1_ff || rdy2;

   assign ctl.en_sq  = rdy2;
   assign ctl.en_sum = rdy3;
   assign ctl.en_asg = rdy4;
   assign ctl.en_out = rdy5;

   always_comb begin
      v1_in = req_ready ? req_valid : v1_ff;
      v2_in = rdy2 ? v1_ff : v2_ff;
      v3_in = rdy3 ? v2_ff : v3_ff;
      v4_in = rdy4 ? v3_ff : v4_ff;
      v5_in = rdy5 ? v4_ff : v5_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
         v4_ff <= v4_in;
         v5_ff <= v5_in;
      end
   end

   assign rsp_valid = v5_ff;

   // bounding box of found points
   logic signed [W-1:0] in_x [qcs_pkg::NUM_PTS];
   logic signed [W-1:0] in_y [qcs_pkg::NUM_PTS];
   logic [qcs_pkg::NUM_PTS-1:0] in_found;
   logic signed [W-1:0] mnx_in, mxx_in, mny_in, mxy_in;
   logic                any_in;

   assign in_x[0] = req_p0_x;
   assign in_y[0] = req_p0_y;
   assign in_x[1] = req_p1_x;
   assign in_y[1] = req_p1_y;
   assign in_x[2] = req_p2_x;
   assign in_y[2] = req_p2_y;
   assign in_found = {req_found2, req_found1, req_found0};

   always_comb begin
      any_in = 1'b0;
      mnx_in = '0;
      mxx_in = '0;
      mny_in = '0;
      mxy_in = '0;
      for (int n = 0; n < qcs_pkg::NUM_PTS; n++) begin
         if (in_found[n]) begin
            if (!any_in) begin
               mnx_in = in_x[n];
               mxx_in = in_x[n];
               mny_in = in_y[n];
               mxy_in = in_y[n];
            end else begin
               if (in_x[n] < mnx_in) mnx_in = in_x[n];
               if (in_x[n] > mxx_in) mxx_in = in_x[n];
               if (in_y[n] < mny_in) mny_in = in_y[n];
               if (in_y[n] > mxy_in) mxy_in = in_y[n];
            end
            any_in = 1'b1;
         end
      end
   end

   logic signed [W-1:0] px_ff [qcs_pkg::NUM_PTS];
   logic signed [W-1:0] py_ff [qcs_pkg::NUM_PTS];
   logic signed [W-1:0] mnx_ff, mxx_ff, mny_ff, mxy_ff;
   logic                any_s1_ff, any_s2_ff, any_s3_ff;

   always_ff @(posedge clock) begin
      if (req_ready) begin
         px_ff     <= in_x;
         py_ff     <= in_y;
         mnx_ff    <= mnx_in;
         mxx_ff    <= mxx_in;
         mny_ff    <= mny_in;
         mxy_ff    <= mxy_in;
         any_s1_ff <= any_in;
      end
      if (ctl.en_sq) begin
         any_s2_ff <= any_s1_ff;
      end
      if (ctl.en_sum) begin
         any_s3_ff <= any_s2_ff;
      end
   end

   // one distance lane per point
   logic [2*W:0]        dist_s3 [qcs_pkg::NUM_PTS][qcs_pkg::NUM_CRN];
   logic signed [W-1:0] px_s3 [qcs_pkg::NUM_PTS];
   logic signed [W-1:0] py_s3 [qcs_pkg::NUM_PTS];

   for (genvar n = 0; n < qcs_pkg::NUM_PTS; n++) begin : g_lane
      qcs_lane #(
         .W (W)
      ) u_lane (
         .clock    (clock),
         .ctl      (ctl),
         .pt_x     (px_ff[n]),
         .pt_y     (py_ff[n]),
         .min_x    (mnx_ff),
         .max_x    (mxx_ff),
         .min_y    (mny_ff),
         .max_y    (mxy_ff),
         .pt_x_o   (px_s3[n]),
         .pt_y_o   (py_s3[n]),
         .crn_dist (dist_s3[n])
      );
   end

   logic signed [W-1:0] crn_x [qcs_pkg::NUM_CRN];
   logic signed [W-1:0] crn_y [qcs_pkg::NUM_CRN];
   logic [1:0]          stat  [qcs_pkg::NUM_CRN];

   qcs_merge #(
      .W (W)
   ) u_merge (
      .clock    (clock),
      .reset    (reset),
      .ctl      (ctl),
      .asg_vld  (v4_ff),
      .any_in   (any_s3_ff),
      .crn_dist (dist_s3),
      .pt_x     (px_s3),
      .pt_y     (py_s3),
      .crn_x    (crn_x),
      .crn_y    (crn_y),
      .stat     (stat)
   );

   assign rsp_c0_x  = crn_x[0];
   assign rsp_c0_y  = crn_y[0];
   assign rsp_c1_x  = crn_x[1];
   assign rsp_c1_y  = crn_y[1];
   assign rsp_c2_x  = crn_x[2];
   assign rsp_c2_y  = crn_y[2];
   assign rsp_c3_x  = crn_x[3];
   assign rsp_c3_y  = crn_y[3];
   assign rsp_stat0 = stat[0];
   assign rsp_stat1 = stat[1];
   assign rsp_stat2 = stat[2];
   assign rsp_stat3 = stat[3];

   a_one_interp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($countones({rsp_stat0 == qcs_pkg::STAT_INTERP,
                                 rsp_stat1 == qcs_pkg::STAT_INTERP,
                                 rsp_stat2 == qcs_pkg::STAT_INTERP,
                                 rsp_stat3 == qcs_pkg::STAT_INTERP}) == 1))
      else $error("response must carry exactly one extrapolated corner");

   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> v1_ff)
      else $error("accepted transaction did not enter the first stage");

   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (v1_ff && v2_ff && v3_ff && v4_ff && v5_ff))
      else $error("request stalled while the pipeline has room");

endmodule
